[hw/rtl/ctm_pkg.sv]
package ctm_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned MaxMatches        = 16;
  localparam int unsigned MatchCntW         = $clog2(MaxMatches + 1);
  localparam int unsigned RemovedMax        = 31;

  localparam logic [1:0] DomStar    = 2'h1;
  localparam logic [1:0] DowStar    = 2'h2;
  localparam logic [7:0] SundayBits = 8'h81;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RES_INSERT = 2'd0,
    RES_DELETE = 2'd1,
    RES_MATCH  = 2'd2
  } res_kind_e;

  typedef enum logic [1:0] {
    STAT_ADDED     = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] object_id;
    logic [15:0] attribute_id;
    logic        any_attribute;
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] day_mask;
    logic [11:0] month_mask;
    logic [7:0]  weekday_mask;
    logic [1:0]  star_flags;
    logic [22:0] tick_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [4:0]  removed_count;
    logic [23:0] match_object;
    logic [15:0] match_attribute;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] object;
    logic [15:0] attribute;
    logic [59:0] minutes;
    logic [23:0] hours;
    logic [30:0] days;
    logic [11:0] months;
    logic [7:0]  weekdays;
    logic [1:0]  stars;
  } slot_t;

  typedef struct packed {
    logic dup;
    logic del_hit;
    logic tick_hit;
  } cmp_t;

  function automatic slot_t make_slot(in_item_t item);
    slot_t s;
    logic [7:0] wd;
    wd = item.weekday_mask;
    if ((wd & SundayBits) != 8'h00) begin
      wd = wd | SundayBits;
    end
    s.object    = item.object_id;
    s.attribute = item.attribute_id;
    s.minutes   = item.minute_mask;
    s.hours     = item.hour_mask;
    s.days      = item.day_mask;
    s.months    = item.month_mask;
    s.weekdays  = wd;
    s.stars     = item.star_flags;
    return s;
  endfunction

endpackage

[hw/rtl/ctm_if.sv]
interface ctm_in_if;
  import ctm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ctm_out_if;
  import ctm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/ctm_ram.sv]
module ctm_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ctm_cmp.sv]
module ctm_cmp (
  input  ctm_pkg::slot_t    slot_i,
  input  ctm_pkg::in_item_t item_i,
  output ctm_pkg::cmp_t     res_o
);
  import ctm_pkg::*;

  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [2:0]  wday;
  logic [63:0] min_ext;
  logic [31:0] hour_ext;
  logic [31:0] day_ext;
  logic [15:0] mon_ext;
  logic [4:0]  day_idx;
  logic [3:0]  mon_idx;
  logic        dom_hit;
  logic        dow_hit;
  logic        day_ok;
  logic        starred;

  assign minute = item_i.tick_time[5:0];
  assign hour   = item_i.tick_time[10:6];
  assign day    = item_i.tick_time[15:11];
  assign month  = item_i.tick_time[19:16];
  assign wday   = item_i.tick_time[22:20];

  assign min_ext  = {4'b0, slot_i.minutes};
  assign hour_ext = {8'b0, slot_i.hours};
  assign day_ext  = {1'b0, slot_i.days};
  assign mon_ext  = {4'b0, slot_i.months};
  assign day_idx  = day - 5'd1;
  assign mon_idx  = month - 4'd1;

  assign dom_hit = (day != 5'd0) && day_ext[day_idx];
  assign dow_hit = slot_i.weekdays[wday];
  assign starred = (slot_i.stars & (DomStar | DowStar)) != 2'b00;
  assign day_ok  = starred ? (dom_hit && dow_hit) : (dom_hit || dow_hit);

  assign res_o.tick_hit = min_ext[minute] && hour_ext[hour] && (month != 4'd0) &&
                          mon_ext[mon_idx] && day_ok;
  assign res_o.dup      = (slot_i == make_slot(item_i));
  assign res_o.del_hit  = (slot_i.object == item_i.object_id) &&
                          (item_i.any_attribute || (slot_i.attribute == item_i.attribute_id));

endmodule

[hw/rtl/cron_entry_table_matcher.sv]
// Cron entry table with TABLE_DEPTH slots held in one RAM, oldest entry at
// address 0, kept compacted.
// in_i carries items: insert, delete or minute tick. out_o carries results:
// one status for an insert, one removed count for a delete, and one item per
// matching entry for a tick, newest first, at most 16, last set on the final
// one. A tick with no match, or with events disabled, and an unknown kind
// give no result. cfg_we_i/cfg_wdata_i write the events enable bit.
// One item is taken at a time: each item scans the stored entries through a
// single read port and one shared compare unit, one slot per cycle while no
// receiver stall holds a tick with several matches. The next item is taken
// only after the scan of the last one has ended and its final result, if
// any, has been registered.
// An insert writes the new slot when its status leaves; a delete writes kept
// slots down to compact the table during its scan.
// A result waits in an output register; the next item is taken while it
// waits. When the receiver stalls, a tick scan holds at the next match.
// Reset empties the table and sets events enable; no clearing pass is run.
module cron_entry_table_matcher #(
  parameter int unsigned TABLE_DEPTH = ctm_pkg::TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  ctm_in_if.sink           in_i,
  ctm_out_if.source        out_o
);
  import ctm_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RW = (CW > 5) ? CW : 5;
  localparam int unsigned SW = $bits(slot_t);

  state_e                 state_q, state_d;
  in_item_t               item_q, item_d;
  logic                   en_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          step_q, step_d;
  logic [CW-1:0]          keep_q, keep_d;
  logic                   ev_v_q, ev_v_d;
  logic [AW-1:0]          ev_addr_q, ev_addr_d;
  logic                   dup_q, dup_d;
  logic [MatchCntW-1:0]   nmatch_q, nmatch_d;
  logic                   pend_v_q, pend_v_d;
  logic [23:0]            pend_obj_q, pend_obj_d;
  logic [15:0]            pend_attr_q, pend_attr_d;
  logic                   out_v_q, out_v_d;
  out_item_t              out_q, out_d;

  logic                   in_ready;
  logic                   out_free;
  logic                   is_tick;
  logic                   more;
  logic                   take;
  logic                   stall;
  logic                   scan_end;
  logic                   full;
  logic [CW-1:0]          down_pos;
  logic [AW-1:0]          scan_addr;
  logic [CW-1:0]          removed;
  logic [RW-1:0]          removed_w;
  logic [4:0]             removed_sat;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  slot_t                  ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [SW-1:0]          ram_rdata;
  slot_t                  rslot;
  cmp_t                   cmp;

  ctm_ram #(
    .WIDTH  (SW),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rslot = slot_t'(ram_rdata);

  ctm_cmp u_cmp (
    .slot_i (rslot),
    .item_i (item_q),
    .res_o  (cmp)
  );

  assign out_free  = !out_v_q || out_o.ready;
  assign is_tick   = (item_q.kind == KIND_TICK);
  assign more      = (step_q != cnt_q);
  assign take      = ev_v_q && cmp.tick_hit && (nmatch_q != MatchCntW'(MaxMatches));
  assign stall     = is_tick && take && pend_v_q && !out_free;
  assign scan_end  = (!ev_v_q && !more) ||
                     (is_tick && (nmatch_q == MatchCntW'(MaxMatches)));
  assign full      = (cnt_q == CW'(TABLE_DEPTH));
  assign down_pos  = cnt_q - step_q - CW'(1);
  assign scan_addr = is_tick ? down_pos[AW-1:0] : step_q[AW-1:0];
  assign removed   = cnt_q - keep_q;
  assign removed_w = RW'(removed);
  assign removed_sat = (removed_w > RW'(RemovedMax)) ? 5'(RemovedMax) : removed_w[4:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (in_i.payload.kind)
            KIND_INSERT, KIND_DELETE: state_d = S_SCAN;
            KIND_TICK:                state_d = en_q ? S_SCAN : S_IDLE;
            default:                  state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          if (is_tick) begin
            state_d = pend_v_q ? S_DRAIN : S_IDLE;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_RESP, S_DRAIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    item_d      = item_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    keep_d      = keep_q;
    ev_v_d      = ev_v_q;
    ev_addr_d   = ev_addr_q;
    dup_d       = dup_q;
    nmatch_d    = nmatch_q;
    pend_v_d    = pend_v_q;
    pend_obj_d  = pend_obj_q;
    pend_attr_d = pend_attr_q;
    out_v_d     = out_v_q && !out_o.ready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = keep_q[AW-1:0];
    ram_wdata   = rslot;
    ram_raddr   = ev_addr_q;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          item_d   = in_i.payload;
          step_d   = '0;
          keep_d   = '0;
          ev_v_d   = 1'b0;
          dup_d    = 1'b0;
          nmatch_d = '0;
          pend_v_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          ram_raddr = scan_addr;
          ev_addr_d = scan_addr;
          ev_v_d    = more;
          if (more) begin
            step_d = step_q + CW'(1);
          end
        end
        if (ev_v_q) begin
          case (item_q.kind)
            KIND_INSERT: dup_d = dup_q | cmp.dup;
            KIND_DELETE: begin
              if (!cmp.del_hit) begin
                ram_we = 1'b1;
                keep_d = keep_q + CW'(1);
              end
            end
            KIND_TICK: begin
              if (take && !stall) begin
                if (pend_v_q) begin
                  out_v_d               = 1'b1;
                  out_d                 = '0;
                  out_d.result_kind     = RES_MATCH;
                  out_d.match_object    = pend_obj_q;
                  out_d.match_attribute = pend_attr_q;
                end
                pend_v_d    = 1'b1;
                pend_obj_d  = rslot.object;
                pend_attr_d = rslot.attribute;
                nmatch_d    = nmatch_q + MatchCntW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = '0;
          out_d.last = 1'b1;
          case (item_q.kind)
            KIND_INSERT: begin
              out_d.result_kind = RES_INSERT;
              if (dup_q) begin
                out_d.status = STAT_DUPLICATE;
              end else if (full) begin
                out_d.status = STAT_FULL;
              end else begin
                out_d.status = STAT_ADDED;
                ram_we       = 1'b1;
                ram_waddr    = cnt_q[AW-1:0];
                ram_wdata    = make_slot(item_q);
                cnt_d        = cnt_q + CW'(1);
              end
            end
            KIND_DELETE: begin
              out_d.result_kind   = RES_DELETE;
              out_d.removed_count = removed_sat;
              cnt_d               = keep_q;
            end
            default: out_v_d = out_v_q && !out_o.ready;
          endcase
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_v_d               = 1'b1;
          out_d                 = '0;
          out_d.result_kind     = RES_MATCH;
          out_d.match_object    = pend_obj_q;
          out_d.match_attribute = pend_attr_q;
          out_d.last            = 1'b1;
          pend_v_d              = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      en_q     <= 1'b1;
      cnt_q    <= '0;
      step_q   <= '0;
      keep_q   <= '0;
      ev_v_q   <= 1'b0;
      dup_q    <= 1'b0;
      nmatch_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      cnt_q    <= cnt_d;
      step_q   <= step_d;
      keep_q   <= keep_d;
      ev_v_q   <= ev_v_d;
      dup_q    <= dup_d;
      nmatch_q <= nmatch_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    ev_addr_q   <= ev_addr_d;
    pend_obj_q  <= pend_obj_d;
    pend_attr_q <= pend_attr_d;
    out_q       <= out_d;
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

endmodule

[tb/sv/cron_entry_table_matcher_tb.sv]
module cron_entry_table_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctm_pkg::*;

  localparam int unsigned Depth      = TableDepthDefault;
  localparam logic [1:0]  KindUnused = 2'd3;
  localparam int unsigned SettleCyc  = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  ctm_in_if  cron_in ();
  ctm_out_if cron_out ();

  cron_entry_table_matcher i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (cron_in),
    .out_o      (cron_out)
  );

  in_item_t    queued_items[$];
  out_item_t   pending_results[$];
  in_item_t    made_entries[$];
  logic [23:0] obj_pool[$];

  slot_t       cron_slots[Depth];
  int unsigned cron_used = 0;
  logic        events_on = 1'b1;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned src_gap;
  int unsigned sink_gap;

  int unsigned mismatches = 0;
  int unsigned n_checked  = 0;
  int unsigned n_matches  = 0;
  int unsigned n_inserts  = 0;
  int unsigned n_deletes  = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_ignored  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void run_cron_item(in_item_t it);
    slot_t       fresh;
    out_item_t   res;
    out_item_t   hits[$];
    int          i;
    int unsigned keep;
    int unsigned removed;
    int unsigned mn, hr, dy, mo, wd;
    logic        dup, dom_hit, dow_hit, day_ok, clock_hit;
    res = '0;
    res.last = 1'b1;
    case (it.kind)
      KIND_INSERT: begin
        fresh.object    = it.object_id;
        fresh.attribute = it.attribute_id;
        fresh.minutes   = it.minute_mask;
        fresh.hours     = it.hour_mask;
        fresh.days      = it.day_mask;
        fresh.months    = it.month_mask;
        fresh.weekdays  = it.weekday_mask;
        fresh.stars     = it.star_flags;
        if (fresh.weekdays[0] || fresh.weekdays[7]) begin
          fresh.weekdays[0] = 1'b1;
          fresh.weekdays[7] = 1'b1;
        end
        dup = 1'b0;
        for (i = 0; i < cron_used; i++) begin
          if (cron_slots[i] == fresh) begin
            dup = 1'b1;
          end
        end
        res.result_kind = RES_INSERT;
        if (dup) begin
          res.status = STAT_DUPLICATE;
        end else if (cron_used >= Depth) begin
          res.status = STAT_FULL;
        end else begin
          for (i = cron_used; i > 0; i--) begin
            cron_slots[i] = cron_slots[i - 1];
          end
          cron_slots[0] = fresh;
          cron_used++;
          res.status = STAT_ADDED;
        end
        pending_results.push_back(res);
      end
      KIND_DELETE: begin
        keep = 0;
        removed = 0;
        for (i = 0; i < cron_used; i++) begin
          if (cron_slots[i].object == it.object_id &&
              (it.any_attribute || cron_slots[i].attribute == it.attribute_id)) begin
            removed++;
          end else begin
            cron_slots[keep] = cron_slots[i];
            keep++;
          end
        end
        cron_used = keep;
        res.result_kind = RES_DELETE;
        res.removed_count = 5'((removed > RemovedMax) ? RemovedMax : removed);
        pending_results.push_back(res);
      end
      KIND_TICK: begin
        if (events_on) begin
          mn = it.tick_time[5:0];
          hr = it.tick_time[10:6];
          dy = it.tick_time[15:11];
          mo = it.tick_time[19:16];
          wd = it.tick_time[22:20];
          for (i = 0; i < cron_used && hits.size() < MaxMatches; i++) begin
            dom_hit = 1'b0;
            if (dy >= 1) begin
              dom_hit = cron_slots[i].days[dy - 1];
            end
            dow_hit = cron_slots[i].weekdays[wd];
            if ((cron_slots[i].stars & (DomStar | DowStar)) != 2'b00) begin
              day_ok = dom_hit && dow_hit;
            end else begin
              day_ok = dom_hit || dow_hit;
            end
            clock_hit = (mn < 60) && (hr < 24) && (mo >= 1) && (mo <= 12);
            if (clock_hit) begin
              clock_hit = cron_slots[i].minutes[mn] && cron_slots[i].hours[hr] &&
                          cron_slots[i].months[mo - 1];
            end
            if (clock_hit && day_ok) begin
              res = '0;
              res.result_kind     = RES_MATCH;
              res.match_object    = cron_slots[i].object;
              res.match_attribute = cron_slots[i].attribute;
              hits.push_back(res);
            end
          end
          if (hits.size() != 0) begin
            hits[hits.size() - 1].last = 1'b1;
          end
          foreach (hits[j]) begin
            pending_results.push_back(hits[j]);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_item_t make_insert(logic [23:0] obj, logic [15:0] attr,
                                           logic [59:0] mins, logic [23:0] hrs,
                                           logic [30:0] days, logic [11:0] mons,
                                           logic [7:0] wdays, logic [1:0] stars);
    in_item_t it;
    it = '0;
    it.kind         = KIND_INSERT;
    it.object_id    = obj;
    it.attribute_id = attr;
    it.minute_mask  = mins;
    it.hour_mask    = hrs;
    it.day_mask     = days;
    it.month_mask   = mons;
    it.weekday_mask = wdays;
    it.star_flags   = stars;
    return it;
  endfunction

  function automatic in_item_t minute_tick(int unsigned mn, int unsigned hr, int unsigned dy,
                                           int unsigned mo, int unsigned wd);
    in_item_t it;
    it = '0;
    it.kind      = KIND_TICK;
    it.tick_time = {3'(wd), 4'(mo), 5'(dy), 5'(hr), 6'(mn)};
    return it;
  endfunction

  function automatic in_item_t removal(logic [23:0] obj, logic [15:0] attr, logic any);
    in_item_t it;
    it = '0;
    it.kind          = KIND_DELETE;
    it.object_id     = obj;
    it.attribute_id  = attr;
    it.any_attribute = any;
    return it;
  endfunction

  function automatic logic [63:0] rand_mask();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(4))
      0: r = '1;
      1: r = r | {$urandom, $urandom};
      2: r = 64'd1 << $urandom_range(63);
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_bit(logic [63:0] mask, int unsigned width);
    int unsigned pos;
    int          k;
    pos = 0;
    for (k = 0; k < 16; k++) begin
      pos = $urandom_range(width - 1);
      if (mask[pos]) begin
        return pos;
      end
    end
    return pos;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    in_item_t    src;
    logic [63:0] w;
    int unsigned roll;
    w = {$urandom, $urandom};
    it.object_id     = w[23:0];
    it.attribute_id  = w[39:24];
    it.any_attribute = w[40];
    it.tick_time     = w[63:41];
    w = {$urandom, $urandom};
    it.minute_mask   = w[59:0];
    it.star_flags    = w[61:60];
    w = {$urandom, $urandom};
    it.hour_mask     = w[23:0];
    it.day_mask      = w[54:24];
    it.weekday_mask  = w[62:55];
    w = {$urandom, $urandom};
    it.month_mask    = w[11:0];
    roll = $urandom_range(99);
    if (roll < 5) begin
      it.kind = KindUnused;
    end else if (roll < 45) begin
      it.kind = KIND_INSERT;
      if (made_entries.size() != 0 && $urandom_range(4) == 0) begin
        it = made_entries[$urandom_range(made_entries.size() - 1)];
        if ((it.weekday_mask & SundayBits) != 8'h00) begin
          case ($urandom_range(2))
            0: it.weekday_mask = (it.weekday_mask & ~SundayBits) | 8'h01;
            1: it.weekday_mask = (it.weekday_mask & ~SundayBits) | 8'h80;
            default: it.weekday_mask = it.weekday_mask | SundayBits;
          endcase
        end
      end else begin
        if ($urandom_range(9) < 7) begin
          it.object_id = obj_pool[$urandom_range(obj_pool.size() - 1)];
        end
        if ($urandom_range(3) != 0) begin
          it.attribute_id = 16'($urandom_range(3));
        end
        it.minute_mask  = 60'(rand_mask());
        it.hour_mask    = 24'(rand_mask());
        it.day_mask     = 31'(rand_mask());
        it.month_mask   = 12'(rand_mask());
        it.weekday_mask = 8'(rand_mask());
        made_entries.push_back(it);
        if (made_entries.size() > 24) begin
          void'(made_entries.pop_front());
        end
      end
    end else if (roll < 60) begin
      it.kind = KIND_DELETE;
      if (made_entries.size() != 0 && $urandom_range(3) != 0) begin
        src = made_entries[$urandom_range(made_entries.size() - 1)];
        it.object_id = src.object_id;
        if ($urandom_range(1) == 0) begin
          it.attribute_id = src.attribute_id;
        end
      end
    end else begin
      it.kind = KIND_TICK;
      if (made_entries.size() != 0 && $urandom_range(9) < 7) begin
        src = made_entries[$urandom_range(made_entries.size() - 1)];
        it.tick_time = {3'(pick_bit(64'(src.weekday_mask), 7)),
                        4'(pick_bit(64'(src.month_mask), 12) + 1),
                        5'(pick_bit(64'(src.day_mask), 31) + 1),
                        5'(pick_bit(64'(src.hour_mask), 24)),
                        6'(pick_bit(64'(src.minute_mask), 60))};
      end else if ($urandom_range(1) == 0) begin
        it.tick_time = {3'($urandom_range(6)), 4'($urandom_range(1, 12)),
                        5'($urandom_range(1, 31)), 5'($urandom_range(23)),
                        6'($urandom_range(59))};
      end
    end
    return it;
  endfunction

  task automatic write_events_enable(input logic value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    events_on = value;
  endtask

  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (queued_items.size() != 0 || cron_in.valid || pending_results.size() != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic load_random(input int unsigned count, input int unsigned src_pct,
                             input int unsigned sink_pct);
    int unsigned taken;
    in_item_t    it;
    @(negedge clk_i);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    taken = 0;
    while (taken < count) begin
      it = rand_item();
      queued_items.push_back(it);
      if (it.kind != KindUnused) begin
        taken++;
      end
    end
  endtask

  function automatic void flag_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want kind %0d status %0d removed %0d obj %h attr %h last %0d", what,
               want.result_kind, want.status, want.removed_count, want.match_object,
               want.match_attribute, want.last);
      $display("  got kind %0d status %0d removed %0d obj %h attr %h last %0d",
               got.result_kind, got.status, got.removed_count, got.match_object,
               got.match_attribute, got.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cron_in.valid   <= 1'b0;
      cron_in.payload <= '0;
      src_gap         <= 0;
    end else if (!cron_in.valid || cron_in.ready) begin
      if (src_gap != 0) begin
        src_gap       <= src_gap - 1;
        cron_in.valid <= 1'b0;
      end else if (queued_items.size() != 0 && $urandom_range(99) < src_idle_pct) begin
        src_gap       <= $urandom_range(9);
        cron_in.valid <= 1'b0;
      end else if (queued_items.size() != 0) begin
        cron_in.valid   <= 1'b1;
        cron_in.payload <= queued_items.pop_front();
      end else begin
        cron_in.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cron_out.ready <= 1'b0;
      sink_gap       <= 0;
    end else if (sink_gap != 0) begin
      sink_gap       <= sink_gap - 1;
      cron_out.ready <= 1'b0;
    end else if ($urandom_range(99) < sink_idle_pct) begin
      sink_gap       <= $urandom_range(9);
      cron_out.ready <= 1'b0;
    end else begin
      cron_out.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cron_in.valid === 1'b1 && cron_in.ready === 1'b1) begin
      run_cron_item(cron_in.payload);
      case (cron_in.payload.kind)
        KIND_INSERT: n_inserts++;
        KIND_DELETE: n_deletes++;
        KIND_TICK:   n_ticks++;
        default:     n_ignored++;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_ni && cron_out.valid === 1'b1 && cron_out.ready === 1'b1) begin
      got = cron_out.payload;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.result_kind == RES_MATCH) begin
          n_matches++;
        end
        if (got.result_kind !== want.result_kind || got.status !== want.status ||
            got.removed_count !== want.removed_count ||
            got.match_object !== want.match_object ||
            got.match_attribute !== want.match_attribute || got.last !== want.last) begin
          flag_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  initial begin : stimulus
    int k;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    obj_pool = '{24'h000000, 24'hFFFFFF};
    repeat (4) obj_pool.push_back(24'($urandom));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_events_enable(1'b0);
    @(negedge clk_i);
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    queued_items.push_back(make_insert(24'h0, 16'h0, '1, '1, '1, '1, 8'h01, 2'd0));
    queued_items.push_back(minute_tick(0, 0, 1, 1, 0));
    wait_quiet();
    write_events_enable(1'b1);

    @(negedge clk_i);
    queued_items.push_back(make_insert(24'h0, 16'h0, '1, '1, '1, '1, 8'h80, 2'd0));
    queued_items.push_back(make_insert('1, '1, 60'd1 << 59, 24'd1 << 23, 31'd1 << 30,
                                       12'd1 << 11, 8'h40, 2'd3));
    queued_items.push_back(minute_tick(59, 23, 31, 12, 6));
    queued_items.push_back(minute_tick(59, 23, 31, 12, 5));
    queued_items.push_back(make_insert(24'h123456, 16'h1, '1, '1,
                                       (31'd1 << 14) | (31'd1 << 30), '1, 8'h02, 2'd0));
    queued_items.push_back(minute_tick(10, 5, 15, 6, 3));
    queued_items.push_back(minute_tick(10, 5, 3, 6, 1));
    queued_items.push_back(minute_tick(63, 5, 3, 6, 1));
    queued_items.push_back(minute_tick(10, 31, 3, 0, 1));
    queued_items.push_back(minute_tick(10, 5, 0, 6, 7));
    queued_items.push_back(minute_tick(10, 5, 3, 15, 1));
    queued_items.push_back(removal(24'h0, 16'h0, 1'b0) ^ in_item_t'({KindUnused ^ KIND_DELETE,
                                                                     201'd0}));
    queued_items.push_back(removal(24'h0, 16'h5, 1'b0));
    for (k = 0; k < 13; k++) begin
      queued_items.push_back(make_insert(24'hABCDEF, 16'(k), '1, '1, '1, '1, 8'hFF, 2'(k)));
    end
    queued_items.push_back(make_insert(24'hABCDEF, 16'd99, '1, '1, '1, '1, 8'hFF, 2'd0));
    queued_items.push_back(make_insert(24'hABCDEF, 16'd0, '1, '1, '1, '1, 8'hFF, 2'd0));
    queued_items.push_back(minute_tick(59, 23, 31, 12, 6));
    queued_items.push_back(removal(24'hABCDEF, 16'h0, 1'b1));
    queued_items.push_back(removal(24'h0, 16'h0, 1'b0));
    queued_items.push_back(removal(24'h123456, 16'hFFFF, 1'b1));
    wait_quiet();

    load_random(180, 25, 40);
    wait_quiet();
    write_events_enable(1'b0);
    load_random(36, 0, 50);
    wait_quiet();
    write_events_enable(1'b1);
    load_random(140, 40, 10);
    wait_quiet();
    load_random(54, 0, 0);
    wait_quiet();

    if (pending_results.size() != 0) begin
      flag_mismatch("missing result", pending_results[0], '0);
    end
    $display("checked %0d results (%0d matched entries) from %0d inserts, %0d deletes,",
             n_checked, n_matches, n_inserts, n_deletes);
    $display("%0d minute ticks and %0d ignored items; %0d mismatches",
             n_ticks, n_ignored, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
